// File: rtl/swqt_pkg.sv
// Shared types and constants for the semaphore wait-queue table.
package swqt_pkg;
	localparam int NUM_PROCS = 32;
	localparam int KEY_WIDTH = 32;
	localparam int PW = $clog2(NUM_PROCS);
	localparam int CW = $clog2(NUM_PROCS + 1);

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_OUT    = 2'd2,
		REQ_PEEK   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_BLOCKED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_WALK,
		S_EXEC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic rd;
		logic walk_step;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic walk_done;
		logic early;
	} sts_t;
endpackage

// File: rtl/swqt_ctrl.sv
// Controller state machine for the semaphore wait-queue table.
module swqt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_busy,
	input  logic [1:0]    req_q,
	input  swqt_pkg::sts_t sts,
	output swqt_pkg::cmd_t cmd,
	output logic          idle,
	output logic          done
);
	import swqt_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_SCAN;
			S_SCAN: begin
				if (sts.early) state_d = S_DONE;
				else if (sts.scan_done) state_d = S_READ;
			end
			S_READ: state_d = (req_q == REQ_OUT) ? S_WALK : S_EXEC;
			S_WALK: if (sts.walk_done) state_d = S_EXEC;
			S_EXEC: state_d = S_DONE;
			S_DONE: if (!out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = 1'b0;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				cmd.load = in_fire;
				cmd.scan_start = in_fire;
			end
			S_SCAN: cmd.scan_step = 1'b1;
			S_READ: cmd.rd = 1'b1;
			S_WALK: cmd.walk_step = 1'b1;
			S_EXEC: cmd.exec = 1'b1;
			S_DONE: done = !out_busy;
			default: idle = 1'b0;
		endcase
	end
endmodule

// File: rtl/swqt_dp.sv
// Datapath: descriptor and link stores, key scan, queue walk and update.
module swqt_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  swqt_pkg::cmd_t           cmd,
	input  logic [1:0]               req_type,
	input  logic [31:0]              sem_key,
	input  logic [4:0]               pid,
	output logic [1:0]               req_q_o,
	output swqt_pkg::sts_t           sts,
	output logic [1:0]               res_status,
	output logic                     res_valid,
	output logic [4:0]               res_pid
);
	import swqt_pkg::*;

	logic [NUM_PROCS-1:0] act_q, blk_q;
	logic [KEY_WIDTH-1:0] key_mem [NUM_PROCS];
	logic [PW-1:0] head_mem [NUM_PROCS];
	logic [PW-1:0] tail_mem [NUM_PROCS];
	logic [PW-1:0] link_mem [NUM_PROCS];
	logic [PW-1:0] pdesc_mem [NUM_PROCS];
	logic [PW-1:0] free_mem [NUM_PROCS];
	logic [CW-1:0] free_top_q;
	logic [NUM_PROCS-1:0] free_init_q;

	logic [1:0] req_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [4:0] pid_q;
	logic [PW-1:0] ppid;
	logic pid_ok;
	logic [CW-1:0] idx_q;
	logic found_q;
	logic [PW-1:0] d_q, h_q, t_q, prev_q, pl_q;
	logic [PW-1:0] fr_q;
	logic walk_found_q;
	logic [1:0] st_q;
	logic v_q;
	logic [4:0] rp_q;
	logic [PW-1:0] ix;
	logic hit;

	assign req_q_o = req_q;
	assign ppid = pid_q[PW-1:0];
	assign pid_ok = 32'(pid_q) < NUM_PROCS;
	assign ix = idx_q[PW-1:0];
	assign hit = act_q[ix] && key_mem[ix] == key_q;
	assign sts.scan_done = found_q || idx_q == CW'(NUM_PROCS) ||
		(idx_q < CW'(NUM_PROCS) && hit) || req_q == REQ_OUT;
	assign sts.early = (req_q == REQ_INSERT && (!pid_ok || blk_q[ppid])) ||
		(req_q == REQ_OUT && (!pid_ok || !blk_q[ppid]));
	assign sts.walk_done = walk_found_q || h_q == ppid || prev_q == t_q;
	assign res_status = st_q;
	assign res_valid = v_q;
	assign res_pid = rp_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= KEY_WIDTH'(sem_key);
			pid_q <= pid;
		end
		if (cmd.scan_step) begin
			if (sts.early) begin
				st_q <= (req_q == REQ_INSERT && pid_ok) ? ST_BLOCKED : ST_NOTFOUND;
				v_q <= 1'b0;
				rp_q <= '0;
			end else if (req_q == REQ_OUT) begin
				d_q <= pdesc_mem[ppid];
			end else if (!found_q && idx_q < CW'(NUM_PROCS) && hit) begin
				d_q <= ix;
			end
		end
		if (cmd.rd) begin
			h_q <= head_mem[d_q];
			t_q <= tail_mem[d_q];
			prev_q <= head_mem[d_q];
			fr_q <= free_init_q[free_top_q[PW-1:0] - PW'(1)] ?
				free_mem[free_top_q[PW-1:0] - PW'(1)] : free_top_q[PW-1:0] - PW'(1);
			pl_q <= link_mem[ppid];
			walk_found_q <= 1'b0;
		end
		if (cmd.walk_step && !sts.walk_done) begin
			if (link_mem[prev_q] == ppid) walk_found_q <= 1'b1;
			else prev_q <= link_mem[prev_q];
		end
		if (cmd.exec) begin
			unique case (req_q)
				REQ_INSERT: begin
					v_q <= 1'b0;
					rp_q <= '0;
					st_q <= (!found_q && free_top_q == '0) ? ST_NO_FREE : ST_OK;
					if (!found_q) begin
						if (free_top_q != '0) begin
							key_mem[fr_q] <= key_q;
							head_mem[fr_q] <= ppid;
							tail_mem[fr_q] <= ppid;
							pdesc_mem[ppid] <= fr_q;
						end
					end else begin
						link_mem[t_q] <= ppid;
						tail_mem[d_q] <= ppid;
						pdesc_mem[ppid] <= d_q;
					end
				end
				REQ_REMOVE, REQ_PEEK: begin
					if (!found_q) begin
						st_q <= ST_NOTFOUND;
						v_q <= 1'b0;
						rp_q <= '0;
					end else begin
						st_q <= ST_OK;
						v_q <= 1'b1;
						rp_q <= 5'(h_q);
						if (req_q == REQ_REMOVE && t_q != h_q)
							head_mem[d_q] <= link_mem[h_q];
					end
				end
				REQ_OUT: begin
					st_q <= ST_OK;
					v_q <= 1'b1;
					rp_q <= pid_q;
					if (h_q == ppid) begin
						if (t_q != ppid) head_mem[d_q] <= pl_q;
					end else if (walk_found_q) begin
						if (t_q == ppid) tail_mem[d_q] <= prev_q;
						else link_mem[prev_q] <= pl_q;
					end
				end
				default: begin
					st_q <= ST_OK;
					v_q <= 1'b0;
					rp_q <= '0;
				end
			endcase
		end
		if (cmd.exec && free_top_q < CW'(NUM_PROCS)) begin
			if ((req_q == REQ_REMOVE && found_q && t_q == h_q) ||
				(req_q == REQ_OUT && h_q == ppid && t_q == ppid))
				free_mem[free_top_q[PW-1:0]] <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			blk_q <= '0;
			free_top_q <= CW'(NUM_PROCS);
			free_init_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				idx_q <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step && !found_q) begin
				if (req_q == REQ_OUT) found_q <= 1'b1;
				else if (idx_q < CW'(NUM_PROCS) && hit) found_q <= 1'b1;
				else if (idx_q < CW'(NUM_PROCS)) idx_q <= idx_q + CW'(1);
			end
			if (cmd.exec) begin
				unique case (req_q)
					REQ_INSERT: begin
						if (!found_q) begin
							if (free_top_q != '0) begin
								free_top_q <= free_top_q - CW'(1);
								act_q[fr_q] <= 1'b1;
								blk_q[ppid] <= 1'b1;
							end
						end else blk_q[ppid] <= 1'b1;
					end
					REQ_REMOVE: if (found_q) begin
						blk_q[h_q] <= 1'b0;
						if (t_q == h_q) begin
							act_q[d_q] <= 1'b0;
							if (free_top_q < CW'(NUM_PROCS)) begin
								free_top_q <= free_top_q + CW'(1);
								free_init_q[free_top_q[PW-1:0]] <= 1'b1;
							end
						end
					end
					REQ_OUT: begin
						blk_q[ppid] <= 1'b0;
						if (h_q == ppid && t_q == ppid) begin
							act_q[d_q] <= 1'b0;
							if (free_top_q < CW'(NUM_PROCS)) begin
								free_top_q <= free_top_q + CW'(1);
								free_init_q[free_top_q[PW-1:0]] <= 1'b1;
							end
						end
					end
					default: free_top_q <= free_top_q;
				endcase
			end
		end
	end
endmodule

// File: rtl/semaphore_wait_queue_table.sv
// Top level of the semaphore wait-queue table.
// channel  | handshake         | payload
// request  | in_valid/in_ready | req_type sem_key pid
// result   | out_valid/out_ready | status pid_valid result_pid
// One request at a time, in steps load, key scan (one descriptor a
// cycle), read, queue walk for a take-out (one link a cycle), update
// and hand-off.
// Reset empties all queues and fills the free stack at once.
// A stalled result holds; the next request is taken while it waits.
module semaphore_wait_queue_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] sem_key,
	input  logic [4:0]  pid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        pid_valid,
	output logic [4:0]  result_pid
);
	import swqt_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic idle, done, in_fire;
	logic [1:0] req_q, st;
	logic v;
	logic [4:0] rp;

	assign in_fire = in_valid && in_ready;

	swqt_ctrl u_ctrl (.clk, .arst_n, .in_fire, .out_busy(out_valid && !out_ready),
		.req_q, .sts, .cmd, .idle, .done);
	swqt_dp u_dp (.clk, .arst_n, .cmd, .req_type, .sem_key, .pid, .req_q_o(req_q),
		.sts, .res_status(st), .res_valid(v), .res_pid(rp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (done) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (done) begin
			status <= st;
			pid_valid <= v;
			result_pid <= rp;
		end
	end
	assign in_ready = idle;

	a_one: assert property (@(posedge clk) disable iff (!arst_n) done |=> out_valid)
		else $error("result lost");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready) else $error("second request accepted");
	a_pv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pid_valid |-> result_pid == 5'd0) else $error("stray pid");
endmodule
